/* rtl/core/tno_pkg.sv */
// Shared types and constants for the telnet option negotiator.
// No dependencies; the decoder, the emitter, the top level and the testbench import this package.
package tno_pkg;

    localparam logic [7:0] IAC_BYTE  = 8'hFF;
    localparam logic [7:0] CMD_SE    = 8'hF0;
    localparam logic [7:0] CMD_SB    = 8'hFA;
    localparam logic [7:0] CMD_WILL  = 8'hFB;
    localparam logic [7:0] CMD_WONT  = 8'hFC;
    localparam logic [7:0] CMD_DO    = 8'hFD;
    localparam logic [7:0] OPT_NAWS  = 8'h1F;
    localparam logic [7:0] OPT_TTYPE = 8'h18;

    localparam logic       DEST_TERM   = 1'b0;
    localparam logic       DEST_REMOTE = 1'b1;

    localparam int         REPLY_LEN = 12;
    localparam int         IDX_W     = $clog2(REPLY_LEN);

    localparam logic       CFG_COLUMNS = 1'b0;
    localparam logic       CFG_ROWS    = 1'b1;

    typedef enum logic [2:0] {
        PH_DATA  = 3'd0,
        PH_CMD   = 3'd1,
        PH_OPT   = 3'd2,
        PH_SKIP1 = 3'd3,
        PH_SKIP2 = 3'd4,
        PH_SKIP3 = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        RUN_ONE    = 2'd0,
        RUN_TRIPLE = 2'd1,
        RUN_NAWS   = 2'd2,
        RUN_TTYPE  = 2'd3
    } t_run_kind;

    // One run of result items: a single byte, IAC plus two bytes, or a
    // twelve-byte run that ends in a subnegotiation.
    typedef struct packed {
        t_run_kind  kind;
        logic       dest;
        logic [7:0] second;
        logic [7:0] last;
    } t_run;

    function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            4'd0:    b = IAC_BYTE;
            4'd1:    b = CMD_SB;
            4'd2:    b = OPT_TTYPE;
            4'd3:    b = 8'h00;
            4'd4:    b = 8'h77;
            4'd5:    b = 8'h73;
            4'd6:    b = 8'h76;
            4'd7:    b = 8'h74;
            4'd8:    b = 8'h32;
            4'd9:    b = 8'h35;
            4'd10:   b = IAC_BYTE;
            4'd11:   b = CMD_SE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/core/tno_in_if.sv */
// Input channel of the telnet option negotiator: byte source and byte.
// Depends on nothing; used by the top level and its test environment.
interface tno_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_in;

    modport source (output valid, output op, output data_in, input ready);
    modport sink (input valid, input op, input data_in, output ready);
endinterface

/* rtl/core/tno_out_if.sv */
// Output channel of the telnet option negotiator: destination, byte, run end.
// Depends on nothing; used by the emitter and the top level.
interface tno_out_if;
    logic       valid;
    logic       ready;
    logic       destination;
    logic [7:0] data_out;
    logic       last_of_run;

    modport source (output valid, output destination, output data_out,
                    output last_of_run, input ready);
    modport sink (input valid, input destination, input data_out,
                  input last_of_run, output ready);
endinterface

/* rtl/core/tno_decode.sv */
// Protocol decoder: holds the negotiation phase and the saved command, and
// turns an accepted item that yields output into a run descriptor. Depends on tno_pkg.
module tno_decode
    import tno_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_op,
    input  logic [7:0] i_data,
    output logic       o_has_run,
    output t_run       o_run
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_cmd, n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DATA;
            r_cmd   <= 8'h00;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_cmd            = r_cmd;
        o_has_run        = 1'b0;
        o_run.kind       = RUN_ONE;
        o_run.dest       = DEST_REMOTE;
        o_run.second     = 8'h00;
        o_run.last       = i_data;
        if (i_op) begin
            o_has_run = 1'b1;
        end else begin
            case (r_phase)
                PH_CMD: begin
                    n_cmd   = i_data;
                    n_phase = PH_OPT;
                end
                PH_OPT: begin
                    n_phase = PH_DATA;
                    if (r_cmd == CMD_DO && i_data == OPT_NAWS) begin
                        o_has_run  = 1'b1;
                        o_run.kind = RUN_NAWS;
                    end else if (r_cmd == CMD_DO && i_data == OPT_TTYPE) begin
                        o_has_run    = 1'b1;
                        o_run.kind   = RUN_TRIPLE;
                        o_run.second = CMD_WILL;
                    end else if (r_cmd == CMD_SB && i_data == OPT_TTYPE) begin
                        n_phase = PH_SKIP1;
                    end else begin
                        o_has_run  = 1'b1;
                        o_run.kind = RUN_TRIPLE;
                        if (r_cmd == CMD_DO) begin
                            o_run.second = CMD_WONT;
                        end else if (r_cmd == CMD_WILL) begin
                            o_run.second = CMD_DO;
                        end
                    end
                end
                PH_SKIP1: begin
                    n_phase = PH_SKIP2;
                end
                PH_SKIP2: begin
                    n_phase = PH_SKIP3;
                end
                PH_SKIP3: begin
                    n_phase    = PH_DATA;
                    o_has_run  = 1'b1;
                    o_run.kind = RUN_TTYPE;
                end
                default: begin
                    n_phase = PH_DATA;
                    if (i_data == IAC_BYTE) begin
                        n_phase = PH_CMD;
                    end else begin
                        o_has_run  = 1'b1;
                        o_run.dest = DEST_TERM;
                    end
                end
            endcase
        end
    end

endmodule

/* rtl/core/tno_emit.sv */
// Run emitter: holds one run descriptor and steps through its bytes, one
// per cycle while the output is not held off, into the output register. Depends on tno_pkg and tno_out_if.
module tno_emit
    import tno_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_load,
    input  t_run              i_run,
    input  logic [15:0]       i_columns,
    input  logic [15:0]       i_rows,
    output logic              o_ready,
    tno_out_if.source         o_out
);

    logic             r_busy;
    t_run             r_run;
    logic [IDX_W-1:0] r_idx;
    logic             r_ovalid;
    logic             r_odest;
    logic [7:0]       r_odata;
    logic             r_olast;

    logic             adv;
    logic             at_end;
    logic [IDX_W-1:0] end_idx;
    logic [7:0]       cur_byte;

    always_comb begin
        case (r_run.kind)
            RUN_ONE:    end_idx = IDX_W'(0);
            RUN_TRIPLE: end_idx = IDX_W'(2);
            default:    end_idx = IDX_W'(REPLY_LEN - 1);
        endcase
    end

    always_comb begin
        cur_byte = 8'h00;
        case (r_run.kind)
            RUN_ONE: begin
                cur_byte = r_run.last;
            end
            RUN_TRIPLE: begin
                case (r_idx)
                    4'd0:    cur_byte = IAC_BYTE;
                    4'd1:    cur_byte = r_run.second;
                    default: cur_byte = r_run.last;
                endcase
            end
            RUN_NAWS: begin
                case (r_idx)
                    4'd0:    cur_byte = IAC_BYTE;
                    4'd1:    cur_byte = CMD_WILL;
                    4'd2:    cur_byte = OPT_NAWS;
                    4'd3:    cur_byte = IAC_BYTE;
                    4'd4:    cur_byte = CMD_SB;
                    4'd5:    cur_byte = OPT_NAWS;
                    4'd6:    cur_byte = i_columns[15:8];
                    4'd7:    cur_byte = i_columns[7:0];
                    4'd8:    cur_byte = i_rows[15:8];
                    4'd9:    cur_byte = i_rows[7:0];
                    4'd10:   cur_byte = IAC_BYTE;
                    default: cur_byte = CMD_SE;
                endcase
            end
            default: begin
                cur_byte = ttype_byte(r_idx);
            end
        endcase
    end

    assign at_end  = (r_idx == end_idx);
    assign adv     = r_busy && (!r_ovalid || o_out.ready);
    assign o_ready = !r_busy || (adv && at_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_accept) begin
                r_busy <= i_load;
            end else if (adv && at_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_odest <= r_run.dest;
            r_odata <= cur_byte;
            r_olast <= at_end;
        end
        if (i_accept && i_load) begin
            r_run <= i_run;
            r_idx <= '0;
        end else if (adv) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.destination = r_odest;
    assign o_out.data_out    = r_odata;
    assign o_out.last_of_run = r_olast;

endmodule

/* rtl/core/telnet_option_negotiator.sv */
// Telnet option negotiator. Plain bytes from the remote host and keyboard
// bytes flow at one item per cycle while the output is not held off: the
// result of an item is held as a pending run in the run emitter and then
// loaded into the output register. A reply to an option request leaves the
// run emitter one byte per cycle (3 or 12 bytes) while the output is not
// held off, and the next item is taken at the edge that loads the last
// reply byte. Bytes that produce no result still wait for a running reply
// to finish. When the output is held off, the input stalls once the output
// register and the pending run are both occupied. Window size registers are
// sampled while the window size reply is sent.
module telnet_option_negotiator
    import tno_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    tno_in_if.sink      i_in,
    tno_out_if.source   o_out
);

    logic [15:0] r_columns;
    logic [15:0] r_rows;
    logic        accept;
    logic        ready;
    logic        has_run;
    t_run        run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 16'd80;
            r_rows    <= 16'd25;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: r_columns <= i_cfg_data;
                CFG_ROWS:    r_rows    <= i_cfg_data;
                default:     r_rows    <= r_rows;
            endcase
        end
    end

    assign i_in.ready = ready;
    assign accept     = i_in.valid && ready;

    tno_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_op      (i_in.op),
        .i_data    (i_in.data_in),
        .o_has_run (has_run),
        .o_run     (run)
    );

    tno_emit u_emit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_load    (has_run),
        .i_run     (run),
        .i_columns (r_columns),
        .i_rows    (r_rows),
        .o_ready   (ready),
        .o_out     (o_out)
    );

endmodule

/* dv/telnet_option_negotiator_tb.sv */
// Self-checking testbench for the telnet option negotiator: directed and random byte streams.
// Depends on tno_pkg, the tno_in_if and tno_out_if interfaces and the block's top level.
module telnet_option_negotiator_tb;
    import tno_pkg::*;

    localparam logic OP_REMOTE   = 1'b0;
    localparam logic OP_KEYBOARD = 1'b1;
    localparam int   SETTLE_CYCLES    = 16;
    localparam int   WATCHDOG_LIMIT   = 2000;
    localparam int   LONG_HOLD_AT     = 150;
    localparam int   LONG_HOLD_CYCLES = 300;
    localparam int   PHASE_ITEMS      = 61;

    class reply_scoreboard;
        typedef struct packed {
            logic       dest;
            logic [7:0] data;
            logic       last;
        } t_result;

        localparam logic [47:0] TTYPE_NAME = "wsvt25";

        t_phase      phase;
        logic [7:0]  saved_cmd;
        logic [15:0] columns;
        logic [15:0] rows;
        t_result     expected_bytes[$];
        int          errors;

        function new();
            phase = PH_DATA;
            saved_cmd = 8'h00;
            columns = 16'd80;
            rows = 16'd25;
            errors = 0;
        endfunction

        function void set_window(logic [15:0] cols, logic [15:0] rws);
            columns = cols;
            rows = rws;
        endfunction

        function void note_accepted_byte(logic op, logic [7:0] b);
            logic [95:0] run;
            logic [7:0]  second;
            logic        dest;
            int          n;
            t_result     r;
            run = '0;
            n = 0;
            dest = DEST_REMOTE;
            if (op == OP_KEYBOARD) begin
                run[95:88] = b;
                n = 1;
            end else begin
                case (phase)
                    PH_CMD: begin
                        saved_cmd = b;
                        phase = PH_OPT;
                    end
                    PH_OPT: begin
                        phase = PH_DATA;
                        if (saved_cmd == CMD_DO && b == OPT_NAWS) begin
                            run = {IAC_BYTE, CMD_WILL, OPT_NAWS, IAC_BYTE, CMD_SB, OPT_NAWS,
                                   columns, rows, IAC_BYTE, CMD_SE};
                            n = 12;
                        end else if (saved_cmd == CMD_DO && b == OPT_TTYPE) begin
                            run = {IAC_BYTE, CMD_WILL, OPT_TTYPE, 72'h0};
                            n = 3;
                        end else if (saved_cmd == CMD_SB && b == OPT_TTYPE) begin
                            phase = PH_SKIP1;
                        end else begin
                            second = 8'h00;
                            if (saved_cmd == CMD_DO) begin
                                second = CMD_WONT;
                            end else if (saved_cmd == CMD_WILL) begin
                                second = CMD_DO;
                            end
                            run = {IAC_BYTE, second, b, 72'h0};
                            n = 3;
                        end
                    end
                    PH_SKIP1: phase = PH_SKIP2;
                    PH_SKIP2: phase = PH_SKIP3;
                    PH_SKIP3: begin
                        phase = PH_DATA;
                        run = {IAC_BYTE, CMD_SB, OPT_TTYPE, 8'h00, TTYPE_NAME, IAC_BYTE, CMD_SE};
                        n = 12;
                    end
                    default: begin
                        phase = PH_DATA;
                        if (b == IAC_BYTE) begin
                            phase = PH_CMD;
                        end else begin
                            dest = DEST_TERM;
                            run[95:88] = b;
                            n = 1;
                        end
                    end
                endcase
            end
            for (int i = 0; i < n; i++) begin
                r.dest = dest;
                r.data = run[95 - 8 * i -: 8];
                r.last = (i == n - 1);
                expected_bytes.push_back(r);
            end
        endfunction

        function void check_delivered_byte(logic dest, logic [7:0] b, logic last);
            t_result want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected item dest=%0d data=%h last=%0d", $time, dest, b, last);
                return;
            end
            want = expected_bytes.pop_front();
            if (dest !== want.dest) begin
                errors++;
                $display("%0t: destination expected %0d actual %0d", $time, want.dest, dest);
            end
            if (b !== want.data) begin
                errors++;
                $display("%0t: data_out expected %h actual %h", $time, want.data, b);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last_of_run expected %0d actual %0d", $time, want.last, last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_data;

    tno_in_if  in_if();
    tno_out_if out_if();

    reply_scoreboard replies;
    int items_sent;
    int results_seen = 0;
    int idle_cycles = 0;
    int rx_wait = 0;
    bit tx_burst;
    bit rx_burst = 1'b0;
    bit long_hold_done = 1'b0;

    telnet_option_negotiator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                replies.check_delivered_byte(out_if.destination, out_if.data_out,
                                             out_if.last_of_run);
                results_seen++;
                if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 11);
                if (results_seen >= LONG_HOLD_AT && !long_hold_done) begin
                    long_hold_done = 1'b1;
                    rx_wait = LONG_HOLD_CYCLES;
                end
            end
            if (rx_wait > 0) begin
                out_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.op <= op;
        in_if.data_in <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        replies.note_accepted_byte(op, b);
        items_sent++;
    endtask

    // A keyboard byte now and then lands in the middle of a negotiation.
    task automatic send_negotiation_byte(input logic [7:0] b);
        logic [7:0] key;
        key = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) send_item(OP_KEYBOARD, key);
        send_item(OP_REMOTE, b);
    endtask

    task automatic send_random_sequence();
        int         pick;
        logic [7:0] cmd;
        logic [7:0] opt;
        logic [7:0] b;
        logic       op;
        pick = $urandom_range(0, 99);
        b = 8'($urandom_range(0, 255));
        if (pick < 30) begin
            b = 8'($urandom_range(0, 254));
            send_item(OP_REMOTE, b);
        end else if (pick < 45) begin
            send_item(OP_KEYBOARD, b);
        end else if (pick < 90) begin
            cmd = 8'($urandom_range(0, 255));
            opt = 8'($urandom_range(0, 255));
            if (pick < 57) begin
                cmd = CMD_DO;
                case ($urandom_range(0, 2))
                    0: opt = OPT_NAWS;
                    1: opt = OPT_TTYPE;
                    default: ;
                endcase
            end else if (pick < 67) begin
                cmd = $urandom_range(0, 1) ? CMD_WILL : CMD_WONT;
            end else if (pick < 79) begin
                cmd = CMD_SB;
                opt = OPT_TTYPE;
            end
            send_item(OP_REMOTE, IAC_BYTE);
            send_negotiation_byte(cmd);
            send_negotiation_byte(opt);
            if (cmd == CMD_SB && opt == OPT_TTYPE) begin
                repeat (3) send_negotiation_byte(8'($urandom_range(0, 255)));
            end
        end else begin
            op = 1'($urandom_range(0, 1));
            send_item(op, b);
        end
    endtask

    task automatic wait_until_drained();
        in_if.valid <= 1'b0;
        while (replies.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [15:0] cols, input logic [15:0] rws);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_COLUMNS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        i_cfg_idx <= CFG_ROWS;
        i_cfg_data <= rws;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        replies.set_window(cols, rws);
    endtask

    task automatic run_directed();
        send_item(OP_REMOTE, 8'h00);
        send_item(OP_KEYBOARD, 8'hFF);
        send_item(OP_REMOTE, IAC_BYTE);
        send_item(OP_REMOTE, CMD_DO);
        send_item(OP_REMOTE, OPT_NAWS);
        send_item(OP_REMOTE, IAC_BYTE);
        send_item(OP_REMOTE, CMD_DO);
        send_item(OP_REMOTE, OPT_TTYPE);
        send_item(OP_REMOTE, IAC_BYTE);
        send_item(OP_REMOTE, CMD_SB);
        send_item(OP_REMOTE, OPT_TTYPE);
        send_item(OP_REMOTE, 8'h00);
        send_item(OP_REMOTE, 8'hFF);
        send_item(OP_REMOTE, 8'h55);
        send_item(OP_REMOTE, IAC_BYTE);
        send_item(OP_REMOTE, CMD_WILL);
        send_item(OP_REMOTE, 8'h01);
        // The doubled IAC is taken as a command, so the third byte is its option.
        send_item(OP_REMOTE, IAC_BYTE);
        send_item(OP_REMOTE, IAC_BYTE);
        send_item(OP_REMOTE, 8'hFF);
        send_item(OP_REMOTE, IAC_BYTE);
        send_item(OP_KEYBOARD, 8'h41);
        send_item(OP_REMOTE, CMD_DO);
        send_item(OP_KEYBOARD, 8'h0D);
        send_item(OP_REMOTE, 8'h05);
    endtask

    initial begin
        logic [15:0] col_settings [4];
        logic [15:0] row_settings [4];
        replies = new();
        items_sent = 0;
        tx_burst = 1'b0;
        col_settings = '{16'h0000, 16'hFFFF, 16'h00FF, 16'h0000};
        row_settings = '{16'h0000, 16'hFFFF, 16'hFF00, 16'h0000};
        col_settings[3] = 16'($urandom_range(0, 65535));
        row_settings[3] = 16'($urandom_range(0, 65535));
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_COLUMNS;
        i_cfg_data <= 16'h0000;
        in_if.valid <= 1'b0;
        in_if.op <= OP_REMOTE;
        in_if.data_in <= 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        wait_until_drained();
        for (int s = 0; s < 4; s++) begin
            write_window(col_settings[s], row_settings[s]);
            while (items_sent < 25 + (s + 1) * PHASE_ITEMS) send_random_sequence();
            wait_until_drained();
        end

        if (replies.expected_bytes.size() != 0) begin
            replies.errors++;
            $display("%0t: %0d expected items never arrived", $time,
                     replies.expected_bytes.size());
        end
        $display("Sent %0d bytes and checked %0d reply and display bytes.", items_sent,
                 results_seen);
        $display("Window sizes ran through reset, zero, all-ones and mixed values.");
        if (replies.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

/* telnet_option_negotiator.f */
rtl/core/tno_pkg.sv
rtl/core/tno_in_if.sv
rtl/core/tno_out_if.sv
rtl/core/tno_decode.sv
rtl/core/tno_emit.sv
rtl/core/telnet_option_negotiator.sv
dv/telnet_option_negotiator_tb.sv
